/* hw/rtl/bas_pkg.sv */
// ----------------------------------------------------------------------------
// bas_pkg
// Shared types and constants for the button activity statistics block.
// ----------------------------------------------------------------------------
package bas_pkg;

    localparam int MAX_LINES = 16;
    localparam int TIME_W    = 48;
    localparam int TICK_W    = 32;
    localparam int CNT_W     = 16;
    localparam int SEQ_W     = 32;
    localparam int IN_DATA_W  = 56;   // 54 field bits, zero filled to 7 bytes
    localparam int OUT_DATA_W = 296;  // 289 field bits, zero filled to 37 bytes

    localparam logic [CNT_W-1:0] CNT_SAT = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_EVENT      = 2'd0,
        OP_CHECKPOINT = 2'd1,
        OP_RESET      = 2'd2,
        OP_ENTRY      = 2'd3
    } t_op;

    // Update controls for one line, valid in the cycle the request commits.
    typedef struct packed {
        logic              clear;     // session reset
        logic              add_time;  // add delta to held time
        logic              tick;      // count one held tick
        logic              press;     // count a press, record start time
        logic              rel;       // count a release, clear start time
        logic [TIME_W-1:0] delta;
        logic [TIME_W-1:0] now;
    } t_line_ctl;

    typedef struct packed {
        logic [CNT_W-1:0]  press_cnt;
        logic [CNT_W-1:0]  release_cnt;
        logic [TICK_W-1:0] held_ticks;
        logic [TIME_W-1:0] held_time;
        logic [TIME_W-1:0] press_start;
    } t_line_stat;

    typedef struct packed {
        logic [SEQ_W-1:0]     input_change_total;
        logic [SEQ_W-1:0]     entry_sequence;
        logic [TIME_W-1:0]    press_start_ms;
        logic [TIME_W-1:0]    held_time_ms;
        logic [TICK_W-1:0]    held_ticks;
        logic [CNT_W-1:0]     release_count;
        logic [CNT_W-1:0]     press_count;
        logic [MAX_LINES-1:0] newly_released;
        logic [MAX_LINES-1:0] newly_pressed;
        logic [MAX_LINES-1:0] state_after;
        logic [MAX_LINES-1:0] state_before;
        logic                 changed;
    } t_result;

endpackage

/* hw/rtl/bas_line.sv */
// ----------------------------------------------------------------------------
// bas_line
// Statistics cell for one button line: counters, held time, press start.
// ----------------------------------------------------------------------------
module bas_line
    import bas_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_line_ctl  i_ctl,
    output t_line_stat o_next
);

    t_line_stat r_stat;
    t_line_stat n_stat;

    always_comb begin
        n_stat = r_stat;
        if (i_ctl.clear) begin
            n_stat = '0;
        end else begin
            if (i_ctl.add_time) begin
                n_stat.held_time = r_stat.held_time + i_ctl.delta;
            end
            if (i_ctl.tick) begin
                n_stat.held_ticks = r_stat.held_ticks + TICK_W'(1);
            end
            if (i_ctl.press) begin
                if (r_stat.press_cnt != CNT_SAT) begin
                    n_stat.press_cnt = r_stat.press_cnt + CNT_W'(1);
                end
                n_stat.press_start = i_ctl.now;
            end
            if (i_ctl.rel) begin
                if (r_stat.release_cnt != CNT_SAT) begin
                    n_stat.release_cnt = r_stat.release_cnt + CNT_W'(1);
                end
                n_stat.press_start = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stat <= '0;
        end else if (i_en) begin
            r_stat <= n_stat;
        end
    end

    // Post-update view, read by the result path in the commit cycle.
    assign o_next = n_stat;

endmodule

/* hw/rtl/button_activity_statistics.sv */
// ----------------------------------------------------------------------------
// button_activity_statistics
// Button mask tracker with per-line press, release, hold time and tick stats.
// ----------------------------------------------------------------------------
// Path: input register, then one pass of update logic into the result register.
// Throughput: one request per cycle unless i_m_tready stalls; the update of all
//   lines is parallel, bounded by the 48-bit timestamp compare/subtract feeding
//   the line adders.
// Reset: synchronous active-low i_rst_n clears the mask, every line's
//   statistics, the checkpoint and both entry counters; both stages empty.
// ----------------------------------------------------------------------------
module button_activity_statistics
    import bas_pkg::*;
#(
    parameter int NUM_LINES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request channel.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // tdata, from bit 0: button_index[3:0], pressed, now_ms[47:0],
    //   is_input_change, zero fill
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // tuser: operation[1:0]
    input  logic [1:0]            i_s_tuser,
    // Result channel.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // tdata, from bit 0: changed, state_before[15:0], state_after[15:0],
    //   newly_pressed[15:0], newly_released[15:0], press_count[15:0],
    //   release_count[15:0], held_ticks[31:0], held_time_ms[47:0],
    //   press_start_ms[47:0], entry_sequence[31:0], input_change_total[31:0],
    //   zero fill
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    localparam int IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam logic [4:0]           NUM_LINES_V = 5'(NUM_LINES);
    localparam logic [MAX_LINES-1:0] LINE_MASK   =
        MAX_LINES'((17'd1 << NUM_LINES) - 17'd1);

    // ---------------------------------------------------------------- input
    logic              r_in_valid;
    t_op               r_op;
    logic [3:0]        r_idx;
    logic              r_lvl;
    logic [TIME_W-1:0] r_now;
    logic              r_ic;

    // ---------------------------------------------------------------- state
    logic [MAX_LINES-1:0] r_state;
    logic [TIME_W-1:0]    r_ckpt;
    logic [SEQ_W-1:0]     r_seq;
    logic [SEQ_W-1:0]     r_chg;

    logic               r_out_valid;
    t_result            r_res;

    logic               fire;     // request moves from input to result stage
    logic               line_ok;
    logic [MAX_LINES-1:0] line_bit;
    logic               was_held;
    logic               changed;
    logic               advance;  // checkpoint moves and held lines tick
    logic               time_gt;
    logic [TIME_W-1:0]  delta;

    logic [MAX_LINES-1:0] n_state;
    logic [TIME_W-1:0]    n_ckpt;
    logic [SEQ_W-1:0]     n_seq;
    logic [SEQ_W-1:0]     n_chg;
    t_result              n_res;

    t_line_ctl  line_ctl  [NUM_LINES];
    t_line_stat line_next [NUM_LINES];
    t_line_stat sel_stat;

    // Advance when the result stage is empty or being drained.
    assign fire       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // Payload needs no reset; capture on every accepted request.
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_op  <= t_op'(i_s_tuser);
            r_idx <= i_s_tdata[3:0];
            r_lvl <= i_s_tdata[4];
            r_now <= i_s_tdata[52:5];
            r_ic  <= i_s_tdata[53];
        end
    end

    // ---------------------------------------------------------- decode/update
    assign line_ok  = {1'b0, r_idx} < NUM_LINES_V;
    assign line_bit = MAX_LINES'(1) << r_idx;
    assign was_held = r_state[r_idx];
    assign changed  = (r_op == OP_EVENT) && line_ok && (was_held != r_lvl);
    assign advance  = changed || (r_op == OP_CHECKPOINT);
    assign time_gt  = r_now > r_ckpt;
    assign delta    = r_now - r_ckpt;

    always_comb begin
        n_state = r_state;
        n_ckpt  = r_ckpt;
        n_seq   = r_seq;
        n_chg   = r_chg;
        unique case (r_op)
            OP_EVENT: begin
                if (changed) begin
                    n_state = r_lvl ? (r_state | line_bit) : (r_state & ~line_bit);
                    n_ckpt  = r_now;
                end
            end
            OP_CHECKPOINT: begin
                n_ckpt = r_now;
            end
            OP_RESET: begin
                n_state = '0;
                n_ckpt  = r_now;
                n_seq   = '0;
                n_chg   = '0;
            end
            OP_ENTRY: begin
                n_seq = r_seq + SEQ_W'(1);
                if (r_ic) begin
                    n_chg = r_chg + SEQ_W'(1);
                end
            end
        endcase
    end

    // Held time accrues over the mask before the change, ticks over the mask after.
    always_comb begin
        for (int i = 0; i < NUM_LINES; i++) begin
            line_ctl[i].clear    = (r_op == OP_RESET);
            line_ctl[i].add_time = advance && time_gt && r_state[i];
            line_ctl[i].tick     = advance && n_state[i];
            line_ctl[i].press    = changed && r_lvl && line_bit[i];
            line_ctl[i].rel      = changed && !r_lvl && line_bit[i];
            line_ctl[i].delta    = delta;
            line_ctl[i].now      = r_now;
        end
    end

    for (genvar gi = 0; gi < NUM_LINES; gi++) begin : g_line
        bas_line u_line (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (fire),
            .i_ctl   (line_ctl[gi]),
            .o_next  (line_next[gi])
        );
    end

    // Report the addressed line after the update; lines out of range read zero.
    assign sel_stat = line_ok ? line_next[r_idx[IDX_W-1:0]] : '0;

    always_comb begin
        n_res                    = '0;
        n_res.changed            = changed;
        n_res.state_before       = (r_op == OP_EVENT) ? r_state : n_state;
        n_res.state_after        = n_state;
        n_res.newly_pressed      = (changed && r_lvl) ? line_bit : '0;
        n_res.newly_released     = (changed && !r_lvl) ? line_bit : '0;
        n_res.press_count        = sel_stat.press_cnt;
        n_res.release_count      = sel_stat.release_cnt;
        n_res.held_ticks         = sel_stat.held_ticks;
        n_res.held_time_ms       = sel_stat.held_time;
        n_res.press_start_ms     = sel_stat.press_start;
        n_res.entry_sequence     = n_seq;
        n_res.input_change_total = n_chg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_ckpt      <= '0;
            r_seq       <= '0;
            r_chg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_state <= n_state;
                r_ckpt  <= n_ckpt;
                r_seq   <= n_seq;
                r_chg   <= n_chg;
            end
            // Hold the result while stalled; load on commit, drop on drain.
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_DATA_W - $bits(t_result))'(0), r_res};

    // ------------------------------------------------------------ assertions
    a_change_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.changed |->
            $onehot(r_res.newly_pressed | r_res.newly_released))
        else $error("changed result without exactly one flipped line");

    a_nochange_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.changed |->
            r_res.newly_pressed == '0 && r_res.newly_released == '0 &&
            r_res.state_before == r_res.state_after)
        else $error("unchanged result reports a flipped line");

    a_mask_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state & ~LINE_MASK) == '0)
        else $error("button mask holds a line beyond the configured count");

    a_session_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_op == OP_RESET |=> r_state == '0 && r_seq == '0 && r_chg == '0)
        else $error("session reset left state behind");

endmodule

/* sim/tb_button_activity_statistics.sv */
// ----------------------------------------------------------------------------
// tb_button_activity_statistics
// Self-checking bench for the button activity statistics block: an in-bench
// predictor tracks the mask and per-line counters, every result is compared
// field by field, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_button_activity_statistics;
    import bas_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESULT_W    = $bits(t_result);
    localparam int QUIET_LIMIT = 1000;
    localparam int PRINT_LIMIT = 50;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Clock, reset and stream signals; every input known from time zero.
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  s_tvalid   = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata    = '0;
    logic [1:0]            s_tuser    = '0;
    logic                  m_tready   = 1'b1;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    // Predicted block state.
    logic [MAX_LINES-1:0] btn_mask;
    logic [CNT_W-1:0]     press_cnt   [MAX_LINES];
    logic [CNT_W-1:0]     release_cnt [MAX_LINES];
    logic [TICK_W-1:0]    tick_cnt    [MAX_LINES];
    logic [TIME_W-1:0]    hold_ms     [MAX_LINES];
    logic [TIME_W-1:0]    start_ms    [MAX_LINES];
    logic [TIME_W-1:0]    checkpoint_ms;
    logic [SEQ_W-1:0]     entry_cnt;
    logic [SEQ_W-1:0]     change_cnt;

    // Reports predicted for accepted requests, oldest first.
    t_result predicted_reports [$];

    logic [TIME_W-1:0] wall_ms = '0;
    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    int stall_left     = 0;
    int quiet_cycles   = 0;
    int requests_sent  = 0;
    int reports_seen   = 0;
    int mismatch_count = 0;

    button_activity_statistics u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),    // button_index, pressed, now_ms, is_input_change
        .i_s_tuser  (s_tuser),    // operation
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)   // changed ... input_change_total, see t_result
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Clear the whole session and park the checkpoint at the given time.
    function automatic void clear_session(logic [TIME_W-1:0] now);
        btn_mask = '0;
        for (int i = 0; i < MAX_LINES; i++) begin
            press_cnt[i]   = '0;
            release_cnt[i] = '0;
            tick_cnt[i]    = '0;
            hold_ms[i]     = '0;
            start_ms[i]    = '0;
        end
        checkpoint_ms = now;
        entry_cnt     = '0;
        change_cnt    = '0;
    endfunction

    // Credit every held line with the time since the checkpoint; a stamp at
    // or before the checkpoint credits nothing.
    function automatic void add_hold_time(logic [TIME_W-1:0] now);
        if (now > checkpoint_ms) begin
            for (int i = 0; i < MAX_LINES; i++)
                if (btn_mask[i]) hold_ms[i] = hold_ms[i] + (now - checkpoint_ms);
        end
    endfunction

    // Move the checkpoint (possibly backwards) and tick every held line.
    function automatic void move_and_tick(logic [TIME_W-1:0] now);
        checkpoint_ms = now;
        for (int i = 0; i < MAX_LINES; i++)
            if (btn_mask[i]) tick_cnt[i] = tick_cnt[i] + TICK_W'(1);
    endfunction

    // Apply one request to the predicted state and return its report.
    function automatic t_result predict_activity(t_op op, logic [3:0] idx, logic lvl,
                                                 logic [TIME_W-1:0] now, logic chg);
        t_result              r;
        logic [MAX_LINES-1:0] line_bit;
        r        = '0;
        line_bit = MAX_LINES'(1) << idx;
        r.state_before = btn_mask;
        case (op)
            OP_EVENT: begin
                if (btn_mask[idx] != lvl) begin
                    r.changed = 1'b1;
                    // hold time accrues over the mask before the flip
                    add_hold_time(now);
                    if (lvl) begin
                        btn_mask |= line_bit;
                        r.newly_pressed = line_bit;
                        if (press_cnt[idx] != CNT_SAT) press_cnt[idx]++;
                        start_ms[idx] = now;
                    end else begin
                        btn_mask &= ~line_bit;
                        r.newly_released = line_bit;
                        if (release_cnt[idx] != CNT_SAT) release_cnt[idx]++;
                        start_ms[idx] = '0;
                    end
                    move_and_tick(now);
                end
            end
            OP_CHECKPOINT: begin
                add_hold_time(now);
                move_and_tick(now);
                r.state_before = btn_mask;
            end
            OP_RESET: begin
                clear_session(now);
                r.state_before = btn_mask;
            end
            default: begin
                entry_cnt++;
                if (chg) change_cnt++;
            end
        endcase
        r.state_after        = btn_mask;
        r.press_count        = press_cnt[idx];
        r.release_count      = release_cnt[idx];
        r.held_ticks         = tick_cnt[idx];
        r.held_time_ms       = hold_ms[idx];
        r.press_start_ms     = start_ms[idx];
        r.entry_sequence     = entry_cnt;
        r.input_change_total = change_cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Drive one request after a random gap and hold it until accepted.
    task automatic send_request(t_op op, logic [3:0] idx, logic lvl,
                                logic [TIME_W-1:0] now, logic chg);
        int gap;
        gap = gaps_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, chg, now, lvl, idx};
        do @(posedge i_clk); while (!o_s_tready);
        predicted_reports.push_back(predict_activity(op, idx, lvl, now, chg));
        requests_sent++;
    endtask

    // Drop the request line and hold off until every predicted report has come back.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (predicted_reports.size() > 0) @(posedge i_clk);
    endtask

    // Advance the request timestamp: mostly forward, sometimes backward,
    // sometimes anywhere in the 48-bit range or right at its top.
    function automatic logic [TIME_W-1:0] next_stamp();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)      wall_ms = wall_ms + TIME_W'($urandom_range(0, 2000));
        else if (pick < 88) wall_ms = wall_ms - TIME_W'($urandom_range(0, 500));
        else if (pick < 95) wall_ms = TIME_W'({$urandom, $urandom});
        else                wall_ms = TIME_MAX - TIME_W'($urandom_range(0, 1000));
        return wall_ms;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: stall at random, check each accepted result
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH at %0t, result %0d, %s: got %0h, expected %0h",
                     $time, reports_seen, what, got, want);
    endtask

    task automatic check_report(t_result got, t_result want);
        if (got.changed !== want.changed)
            report_mismatch("changed", 64'(got.changed), 64'(want.changed));
        if (got.state_before !== want.state_before)
            report_mismatch("state_before", 64'(got.state_before),
                            64'(want.state_before));
        if (got.state_after !== want.state_after)
            report_mismatch("state_after", 64'(got.state_after), 64'(want.state_after));
        if (got.newly_pressed !== want.newly_pressed)
            report_mismatch("newly_pressed", 64'(got.newly_pressed),
                            64'(want.newly_pressed));
        if (got.newly_released !== want.newly_released)
            report_mismatch("newly_released", 64'(got.newly_released),
                            64'(want.newly_released));
        if (got.press_count !== want.press_count)
            report_mismatch("press_count", 64'(got.press_count), 64'(want.press_count));
        if (got.release_count !== want.release_count)
            report_mismatch("release_count", 64'(got.release_count),
                            64'(want.release_count));
        if (got.held_ticks !== want.held_ticks)
            report_mismatch("held_ticks", 64'(got.held_ticks), 64'(want.held_ticks));
        if (got.held_time_ms !== want.held_time_ms)
            report_mismatch("held_time_ms", 64'(got.held_time_ms),
                            64'(want.held_time_ms));
        if (got.press_start_ms !== want.press_start_ms)
            report_mismatch("press_start_ms", 64'(got.press_start_ms),
                            64'(want.press_start_ms));
        if (got.entry_sequence !== want.entry_sequence)
            report_mismatch("entry_sequence", 64'(got.entry_sequence),
                            64'(want.entry_sequence));
        if (got.input_change_total !== want.input_change_total)
            report_mismatch("input_change_total", 64'(got.input_change_total),
                            64'(want.input_change_total));
    endtask

    always @(posedge i_clk) begin : result_side
        t_result got;
        int      stall;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            got = t_result'(o_m_tdata[RESULT_W-1:0]);
            reports_seen++;
            if (o_m_tdata[OUT_DATA_W-1:RESULT_W] !== '0)
                report_mismatch("zero fill", 64'(o_m_tdata[OUT_DATA_W-1:RESULT_W]),
                                64'd0);
            if (predicted_reports.size() == 0)
                report_mismatch("result with no request pending", 64'd0, 64'd0);
            else
                check_report(got, predicted_reports.pop_front());
            // draw the stall before taking the next result
            stall = stalls_on ? $urandom_range(0, 10) : 0;
            stall_left = stall;
            if (stall > 0) m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            if (stall_left == 0) m_tready <= 1'b1;
        end
    end

    // Watchdog: end the run when no request or result moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, predicted_reports.size());
            $display("tb_button_activity_statistics: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes, every operation and each corner of the timing rules.
    task automatic test_directed();
        send_request(OP_ENTRY,      4'd0,  1'b0, TIME_MAX, 1'b1);
        send_request(OP_ENTRY,      4'd15, 1'b1, '0,       1'b0);
        send_request(OP_EVENT,      4'd0,  1'b1, 48'd100,  1'b1);
        // same level again: no change
        send_request(OP_EVENT,      4'd0,  1'b1, 48'd150,  1'b0);
        send_request(OP_EVENT,      4'd15, 1'b1, 48'd200,  1'b0);
        // checkpoint moves backwards, no time credited
        send_request(OP_CHECKPOINT, 4'd0,  1'b0, 48'd50,   1'b0);
        send_request(OP_CHECKPOINT, 4'd15, 1'b1, 48'd300,  1'b1);
        send_request(OP_EVENT,      4'd0,  1'b0, 48'd400,  1'b0);
        send_request(OP_EVENT,      4'd0,  1'b0, 48'd500,  1'b1);
        send_request(OP_EVENT,      4'd7,  1'b0, 48'd600,  1'b0);
        send_request(OP_CHECKPOINT, 4'd15, 1'b0, TIME_MAX, 1'b0);
        // press with a stamp before the checkpoint
        send_request(OP_EVENT,      4'd3,  1'b1, '0,       1'b0);
        // held time of line 15 wraps past 2^48
        send_request(OP_CHECKPOINT, 4'd15, 1'b1, TIME_MAX, 1'b1);
        send_request(OP_CHECKPOINT, 4'd3,  1'b0, TIME_MAX, 1'b0);
        send_request(OP_RESET,      4'd15, 1'b1, TIME_MAX, 1'b1);
        send_request(OP_EVENT,      4'd15, 1'b1, '0,       1'b0);
        send_request(OP_CHECKPOINT, 4'd15, 1'b0, TIME_MAX, 1'b0);
        send_request(OP_ENTRY,      4'd9,  1'b1, 48'h5555_5555_5555, 1'b1);
        send_request(OP_RESET,      4'd0,  1'b0, '0,       1'b0);
    endtask

    // Mostly well-formed press/release traffic with checkpoints and entries,
    // rare session resets, and idling switched on and off in stretches.
    task automatic test_random_traffic(int count);
        int         pick;
        logic [3:0] idx;
        logic       lvl;
        for (int n = 0; n < count; n++) begin
            if (n % 150 == 0) begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            // hold the sender once until everything has drained
            if (n == count / 2) wait_for_drain();
            pick = $urandom_range(0, 99);
            idx  = 4'($urandom_range(0, MAX_LINES - 1));
            lvl  = 1'($urandom_range(0, 1));
            if (pick < 50) begin
                if ($urandom_range(0, 9) < 7) lvl = ~btn_mask[idx];
                send_request(OP_EVENT, idx, lvl, next_stamp(),
                             1'($urandom_range(0, 1)));
            end else if (pick < 72) begin
                send_request(OP_CHECKPOINT, idx, lvl, next_stamp(),
                             1'($urandom_range(0, 1)));
            end else if (pick < 97) begin
                send_request(OP_ENTRY, idx, lvl, TIME_W'({$urandom, $urandom}),
                             1'($urandom_range(0, 1)));
            end else begin
                send_request(OP_RESET, idx, lvl, next_stamp(),
                             1'($urandom_range(0, 1)));
            end
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // Drive one line through a burst of press/release pairs, back to back
    // with no idling on either side.
    task automatic test_back_to_back_burst();
        logic [3:0] idx;
        idx       = 4'($urandom_range(0, MAX_LINES - 1));
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_request(OP_RESET, idx, 1'b0, '0, 1'b0);
        for (int n = 0; n < 20; n++) begin
            send_request(OP_EVENT, idx, 1'b1, 48'(2 * n + 1), 1'b0);
            send_request(OP_EVENT, idx, 1'b0, 48'(2 * n + 2), 1'b0);
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial begin
        clear_session('0);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic(1590);
        test_back_to_back_burst();

        wait_for_drain();
        repeat (10) @(posedge i_clk);

        $display("run: %0d requests sent, %0d results checked, %0d mismatches",
                 requests_sent, reports_seen, mismatch_count);
        $display("run: directed corners, random button traffic, back-to-back bursts");
        if (mismatch_count == 0) begin
            $display("tb_button_activity_statistics: done, clean");
        end else begin
            $display("tb_button_activity_statistics: done, errors");
        end
        $finish;
    end

endmodule
